>>> sv/fat_block_chain_walker_macros.svh
// Assertion macros for the block chain walker.
// Used by fat_block_chain_walker.sv; needs clk and arst_n in scope.
`ifndef FAT_BLOCK_CHAIN_WALKER_MACROS_SVH
`define FAT_BLOCK_CHAIN_WALKER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define FBCW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled in reset.
`define FBCW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/fbcw_pkg.sv
// Shared types and codes for the block chain walker.
// No dependencies; used by fbcw_ctrl, fbcw_dp and the top level.
`default_nettype none

package fbcw_pkg;

	// Input beat field widths
	localparam int CMD_W   = 2;
	localparam int INDEX_W = 14;
	localparam int LINK_W  = 16;
	localparam int BLOCK_W = 16;
	localparam int SIZE_W  = 24;
	localparam int IN_DATA_W = 72;  // 70 bits of fields, padded to bytes

	// Output beat field widths
	localparam int STAT_W  = 2;
	localparam int ADDR_W  = 40;
	localparam int COUNT_W = 14;
	localparam int OUT_DATA_W = 56; // 54 bits of fields, padded to bytes

	// Config register widths
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 40;
	localparam int ENTRIES_W     = 15;
	localparam int CHAIN_W       = 17;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE = 2'd0,
		CMD_START = 2'd1,
		CMD_NEXT  = 2'd2
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_BLOCK  = 2'd0,
		STAT_ACCEPT = 2'd1,
		STAT_REJECT = 2'd2,
		STAT_IDLE   = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE    = 2'd0,
		REG_BLOCKS  = 2'd1,
		REG_ENTRIES = 2'd2,
		REG_MASK    = 2'd3
	} cfg_reg_t;

	// Controller -> datapath
	typedef struct packed {
		logic capture;  // input beat taken this cycle
		logic exec;     // held item executes this cycle
	} ctrl_cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic needs_result; // held item produces an output beat
		logic out_busy;     // output register full and not draining
	} dp_stat_t;

endpackage

`default_nettype wire

>>> sv/fbcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the link table.
`default_nettype none

module fbcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16384
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> sv/fbcw_ctrl.sv
// Controller for the block chain walker: accept / execute sequencing.
// Depends on fbcw_pkg.
`default_nettype none

module fbcw_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire fbcw_pkg::dp_stat_t    stat,
	output fbcw_pkg::ctrl_cmd_t        cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   fire;

	assign in_ready    = (state_q == ST_IDLE);
	// items without a result never wait on the output side
	assign fire        = (state_q == ST_EXEC) && (!stat.needs_result || !stat.out_busy);
	assign cmd.capture = in_valid && in_ready;
	assign cmd.exec    = fire;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.capture) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (fire) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

>>> sv/fbcw_dp.sv
// Datapath for the block chain walker: config, walk state, link table, output register.
// Depends on fbcw_pkg and fbcw_ram.
`default_nettype none

module fbcw_dp #(
	parameter int TABLE_DEPTH = 16384,
	parameter int BLOCK_BYTES = 8192,
	parameter int CHAIN_LIMIT = 100000
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire fbcw_pkg::ctrl_cmd_t                 cmd,
	output fbcw_pkg::dp_stat_t                       stat,
	input  wire logic [fbcw_pkg::IN_DATA_W-1:0]      in_data,
	input  wire logic [fbcw_pkg::CMD_W-1:0]          in_user,
	input  wire logic                                cfg_we,
	input  wire logic [fbcw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [fbcw_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [fbcw_pkg::OUT_DATA_W-1:0]          out_data,
	output logic [fbcw_pkg::STAT_W-1:0]              out_user,
	output logic                                     out_last
);

	localparam int AW   = $clog2(TABLE_DEPTH);
	localparam int BBW  = $clog2(BLOCK_BYTES + 1);
	localparam int PW   = fbcw_pkg::BLOCK_W + BBW;   // block * block size
	localparam int CW   = fbcw_pkg::CHAIN_W;
	localparam int SW   = fbcw_pkg::SIZE_W;
	localparam int IDXX = 17;                        // covers every TABLE_DEPTH
	localparam logic [SW-1:0]   BB_SZ    = SW'(BLOCK_BYTES);
	localparam logic [CW-1:0]   LIMIT    = CW'(CHAIN_LIMIT);
	localparam logic [IDXX-1:0] DEPTH_X  = IDXX'(TABLE_DEPTH);

	// config
	logic [fbcw_pkg::ADDR_W-1:0]    base_q;
	logic [fbcw_pkg::BLOCK_W-1:0]   blocks_q;
	logic [fbcw_pkg::ENTRIES_W-1:0] entries_q;
	logic [fbcw_pkg::LINK_W-1:0]    mask_q;

	// walk state
	logic [fbcw_pkg::BLOCK_W-1:0] cur_block_q;
	logic [SW-1:0]                left_q;
	logic [CW-1:0]                chain_q;
	logic                         active_q;

	// held item
	logic [fbcw_pkg::CMD_W-1:0]   cmd_q;
	logic [fbcw_pkg::INDEX_W-1:0] index_q;
	logic [fbcw_pkg::LINK_W-1:0]  link_q;
	logic [fbcw_pkg::BLOCK_W-1:0] start_q;
	logic [SW-1:0]                size_q;
	logic [PW-1:0]                prod_q;

	// output register
	logic                          out_valid_q;
	logic [fbcw_pkg::STAT_W-1:0]   out_stat_q;
	logic [fbcw_pkg::ADDR_W-1:0]   out_addr_q;
	logic [fbcw_pkg::COUNT_W-1:0]  out_count_q;
	logic                          out_last_q;

	logic [fbcw_pkg::LINK_W-1:0] rd_link;
	logic [IDXX-1:0]             index_x;
	logic                        wr_en;
	logic [SW-1:0]               count;
	logic [SW-1:0]               new_left;
	logic [CW-1:0]               new_chain;
	logic                        off_table;
	logic                        end_link;
	logic                        step_last;
	logic [fbcw_pkg::ADDR_W-1:0] step_addr;
	logic                        start_bad;

	assign index_x = IDXX'(index_q);
	assign wr_en   = cmd.exec && (cmd_q == fbcw_pkg::CMD_WRITE) && (index_x < DEPTH_X);

	fbcw_ram #(
		.WIDTH(fbcw_pkg::LINK_W),
		.DEPTH(TABLE_DEPTH)
	) u_link_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(index_x[AW-1:0]),
		.wr_data(link_q),
		.rd_en  (cmd.capture),
		.rd_addr(cur_block_q[AW-1:0]),
		.rd_data(rd_link)
	);

	assign stat.needs_result = (cmd_q == fbcw_pkg::CMD_START) || (cmd_q == fbcw_pkg::CMD_NEXT);
	assign stat.out_busy     = out_valid_q && !out_ready;

	// next-block step
	assign count     = (left_q < BB_SZ) ? left_q : BB_SZ;
	assign new_left  = left_q - count;
	assign new_chain = chain_q + CW'(1);
	assign off_table = (IDXX'(cur_block_q) >= IDXX'(entries_q)) || (IDXX'(cur_block_q) >= DEPTH_X);
	assign end_link  = (rd_link == '0) || ((rd_link & mask_q) != '0);
	assign step_last = (new_left == '0) || (new_chain >= LIMIT) || off_table || end_link;
	assign step_addr = base_q + fbcw_pkg::ADDR_W'(prod_q);
	assign start_bad = (start_q >= blocks_q) || (size_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= '0;
			blocks_q  <= '0;
			entries_q <= '0;
			mask_q    <= '0;
		end else if (cfg_we) begin
			unique case (fbcw_pkg::cfg_reg_t'(cfg_index))
				fbcw_pkg::REG_BASE:    base_q    <= cfg_data;
				fbcw_pkg::REG_BLOCKS:  blocks_q  <= cfg_data[fbcw_pkg::BLOCK_W-1:0];
				fbcw_pkg::REG_ENTRIES: entries_q <= cfg_data[fbcw_pkg::ENTRIES_W-1:0];
				fbcw_pkg::REG_MASK:    mask_q    <= cfg_data[fbcw_pkg::LINK_W-1:0];
				default: ;
			endcase
		end
	end

	// held item and precomputed block offset (walk state is stable while idle)
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q   <= in_user;
			index_q <= in_data[13:0];
			link_q  <= in_data[29:14];
			start_q <= in_data[45:30];
			size_q  <= in_data[69:46];
			prod_q  <= PW'(cur_block_q) * PW'(BLOCK_BYTES);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_block_q <= '0;
			left_q      <= '0;
			chain_q     <= '0;
			active_q    <= 1'b0;
		end else if (cmd.exec) begin
			unique case (cmd_q)
				fbcw_pkg::CMD_START: begin
					if (start_bad) begin
						active_q <= 1'b0;
					end else begin
						cur_block_q <= start_q;
						left_q      <= size_q;
						chain_q     <= '0;
						active_q    <= (start_q != '0);
					end
				end
				fbcw_pkg::CMD_NEXT: begin
					if (active_q) begin
						left_q  <= new_left;
						chain_q <= new_chain;
						if (step_last) active_q <= 1'b0;
						else cur_block_q <= rd_link;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec && stat.needs_result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && stat.needs_result) begin
			out_addr_q  <= '0;
			out_count_q <= '0;
			out_last_q  <= 1'b0;
			if (cmd_q == fbcw_pkg::CMD_START) begin
				out_stat_q <= start_bad ? fbcw_pkg::STAT_REJECT : fbcw_pkg::STAT_ACCEPT;
			end else if (!active_q) begin
				out_stat_q <= fbcw_pkg::STAT_IDLE;
			end else begin
				out_stat_q  <= fbcw_pkg::STAT_BLOCK;
				out_addr_q  <= step_addr;
				out_count_q <= count[fbcw_pkg::COUNT_W-1:0];
				out_last_q  <= step_last;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {2'b00, out_count_q, out_addr_q};
	assign out_user  = out_stat_q;
	assign out_last  = out_last_q;

endmodule

`default_nettype wire

>>> sv/fat_block_chain_walker.sv
// Top level of the block chain walker: stream ports, config port, assertions.
// Depends on fbcw_pkg, fbcw_ctrl, fbcw_dp, fbcw_ram and the macros header.
`default_nettype none
`include "fat_block_chain_walker_macros.svh"

// Walks file block chains through an on-chip allocation table of 16-bit links.
// Each input beat carries a command in s_axis_tuser: write a table entry, start
// a walk (start block and file size), or ask for the next block. Start and next
// give one output beat: status in m_axis_tuser, block address and byte count in
// m_axis_tdata, end of walk on m_axis_tlast. Table writes give no beat.
// Each item has accept and execute cycles: accept launches the synchronous
// table read at the current block and forms the block offset, execute picks
// the next link and loads the output register. Execute waits only while the
// output register holds an untaken beat and the item has a result; a new item
// is taken while a finished beat still waits downstream. The link table has
// no reset and no clearing pass: entries read back only after they have been
// written. Config must be written only while idle; the block does not check.

module fat_block_chain_walker #(
	parameter int TABLE_DEPTH = 16384,
	parameter int BLOCK_BYTES = 8192,
	parameter int CHAIN_LIMIT = 100000
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// input beats
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// entry_index[13:0], entry_link[29:14], start_block[45:30], file_size[69:46]
	input  wire logic [fbcw_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// command[1:0]
	input  wire logic [fbcw_pkg::CMD_W-1:0]          s_axis_tuser,
	// output beats
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// block_address[39:0], byte_count[53:40]
	output logic [fbcw_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
	// status[1:0]
	output logic [fbcw_pkg::STAT_W-1:0]              m_axis_tuser,
	output logic                                     m_axis_tlast,
	// config write port
	input  wire logic                                cfg_we,
	input  wire logic [fbcw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [fbcw_pkg::CFG_DATA_W-1:0]     cfg_data
);

	fbcw_pkg::ctrl_cmd_t ctl_cmd;
	fbcw_pkg::dp_stat_t  dp_stat;

	fbcw_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.stat    (dp_stat),
		.cmd     (ctl_cmd)
	);

	fbcw_dp #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.BLOCK_BYTES(BLOCK_BYTES),
		.CHAIN_LIMIT(CHAIN_LIMIT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (ctl_cmd),
		.stat     (dp_stat),
		.in_data  (s_axis_tdata),
		.in_user  (s_axis_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (m_axis_tdata),
		.out_user (m_axis_tuser),
		.out_last (m_axis_tlast)
	);

	// an accepted beat is always followed by its execute cycle
	`FBCW_ASSERT_NEXT(a_exec_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "accepted beat skipped execute")

	// only a given block carries address, count and last
	`FBCW_ASSERT_NOW(a_non_block_clean, m_axis_tvalid && (m_axis_tuser != fbcw_pkg::STAT_BLOCK), (m_axis_tdata == '0) && !m_axis_tlast, "non-block result carries payload")

	// a new result beat appears only out of an execute cycle
	`FBCW_ASSERT_NOW(a_result_from_exec, $rose(m_axis_tvalid), $past(!s_axis_tready), "result beat without execute")

endmodule

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for fat_block_chain_walker: table writes, walk starts, next-block beats.
// Needs fbcw_pkg and the walker RTL; expected beats come from a walk model kept in this file.

module testbench;
	import fbcw_pkg::*;

	// Must match the defaults of the block under test
	localparam int TABLE_DEPTH = 16384;
	localparam int BLOCK_BYTES = 8192;
	localparam int CHAIN_LIMIT = 100000;

	// Command code the block ignores; not in the package enum
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	localparam int SETTLE_CYCLES = 8;      // plenty of margin
	localparam int MAX_REPORTS   = 40;
	localparam int DIRECTED_ROWS = 24;
	localparam int FIRST_CFG_ROW = 2;      // rows before this run on reset defaults

	// One input beat, field by field
	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [INDEX_W-1:0] index;
		logic [LINK_W-1:0]  link;
		logic [BLOCK_W-1:0] start;
		logic [SIZE_W-1:0]  size;
	} walk_cmd_t;

	// One output beat, field by field
	typedef struct packed {
		status_t            status;
		logic [ADDR_W-1:0]  addr;
		logic [COUNT_W-1:0] count;
		logic               last;
	} walk_beat_t;

	// Directed row: expectation typed in only where it is obvious
	typedef struct packed {
		walk_cmd_t  cmd;
		logic       typed;
		walk_beat_t want;
	} plan_row_t;

	localparam walk_beat_t NO_WANT     = '{STAT_BLOCK,  40'd0, 14'd0, 1'b0};
	localparam walk_beat_t WANT_ACCEPT = '{STAT_ACCEPT, 40'd0, 14'd0, 1'b0};
	localparam walk_beat_t WANT_REJECT = '{STAT_REJECT, 40'd0, 14'd0, 1'b0};
	localparam walk_beat_t WANT_IDLE   = '{STAT_IDLE,   40'd0, 14'd0, 1'b0};

	// ------------------------------------------------------------------
	// DUT signals, all inputs known from time zero
	// ------------------------------------------------------------------
	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [CMD_W-1:0]      s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [STAT_W-1:0]     m_axis_tuser;
	logic                  m_axis_tlast;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	always #4 clk = ~clk;

	fat_block_chain_walker i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// ------------------------------------------------------------------
	// Walk model: registers, link table, walk state
	// ------------------------------------------------------------------
	logic [ADDR_W-1:0]    m_base    = '0;
	logic [BLOCK_W-1:0]   m_blocks  = '0;
	logic [ENTRIES_W-1:0] m_entries = '0;
	logic [LINK_W-1:0]    m_mask    = '0;

	logic [LINK_W-1:0]    link_mem [TABLE_DEPTH];
	bit                   link_set [TABLE_DEPTH];   // entry written since reset

	logic [BLOCK_W-1:0]   walk_blk  = '0;
	logic [SIZE_W-1:0]    walk_left = '0;
	logic [CHAIN_W-1:0]   walk_hops = '0;
	bit                   walking   = 1'b0;

	walk_beat_t due_beats [$];   // beats the block still owes, oldest first

	// Bookkeeping
	int fail_count   = 0;
	int items_sent   = 0;
	int block_beats  = 0;
	int last_beats   = 0;
	int reject_beats = 0;
	int idle_beats   = 0;

	// Cross-process knobs: receiver hold-off request, sender no-gap modes
	int rx_hold_req = 0;
	bit tx_steady   = 1'b0;
	int tx_calm     = 0;

	// ------------------------------------------------------------------
	// Directed stimulus. Config A (from row FIRST_CFG_ROW on):
	// base 0xFF_FFFF_0000 so addresses wrap, 65535 blocks, full table, mask 0x8000.
	// ------------------------------------------------------------------
	plan_row_t plan [DIRECTED_ROWS] = '{
		// reset defaults: no walk, empty partition
		'{'{CMD_NEXT,  14'd0, 16'd0, 16'd0, 24'd0}, 1'b1, WANT_IDLE},
		'{'{CMD_START, 14'd0, 16'd0, 16'd3, 24'd9}, 1'b1, WANT_REJECT},
		// zero size, then start right at the partition end
		'{'{CMD_START, 14'd0, 16'd0, 16'd5, 24'd0}, 1'b1, WANT_REJECT},
		'{'{CMD_START, 14'd0, 16'd0, 16'hFFFF, 24'hFFFFFF}, 1'b1, WANT_REJECT},
		// table extremes and a few links used below
		'{'{CMD_WRITE, 14'd0, 16'd0, 16'd0, 24'd0}, 1'b0, NO_WANT},
		'{'{CMD_WRITE, 14'h3FFF, 16'hFFFF, 16'd0, 24'd0}, 1'b0, NO_WANT},
		'{'{CMD_WRITE, 14'd5, 16'd6, 16'd0, 24'd0}, 1'b0, NO_WANT},
		'{'{CMD_WRITE, 14'd7, 16'd0, 16'd0, 24'd0}, 1'b0, NO_WANT},
		'{'{CMD_WRITE, 14'd10, 16'h7FFF, 16'd0, 24'd0}, 1'b0, NO_WANT},
		// block zero is accepted but never walked
		'{'{CMD_START, 14'd0, 16'd0, 16'd0, 24'd1}, 1'b1, WANT_ACCEPT},
		'{'{CMD_NEXT,  14'd0, 16'd0, 16'd0, 24'd0}, 1'b1, WANT_IDLE},
		// long walk abandoned by a new start, which ends on a zero link
		'{'{CMD_START, 14'd0, 16'd0, 16'd5, 24'hFFFFFF}, 1'b1, WANT_ACCEPT},
		'{'{CMD_NEXT,  14'd0, 16'd0, 16'd0, 24'd0}, 1'b0, NO_WANT},
		'{'{CMD_START, 14'd0, 16'd0, 16'd7, 24'd9000}, 1'b1, WANT_ACCEPT},
		'{'{CMD_NEXT,  14'd0, 16'd0, 16'd0, 24'd0}, 1'b0, NO_WANT},
		'{'{CMD_NEXT,  14'd0, 16'd0, 16'd0, 24'd0}, 1'b1, WANT_IDLE},
		// short file: bytes run out in the first block
		'{'{CMD_START, 14'd0, 16'd0, 16'd5, 24'd100}, 1'b1, WANT_ACCEPT},
		'{'{CMD_NEXT,  14'd0, 16'd0, 16'd0, 24'd0}, 1'b0, NO_WANT},
		// link past the loaded entries; that block's address wraps
		'{'{CMD_START, 14'd0, 16'd0, 16'd10, 24'd20000}, 1'b1, WANT_ACCEPT},
		'{'{CMD_NEXT,  14'd0, 16'd0, 16'd0, 24'd0}, 1'b0, NO_WANT},
		'{'{CMD_NEXT,  14'd0, 16'd0, 16'd0, 24'd0}, 1'b0, NO_WANT},
		// top entry holds a link with the special bit
		'{'{CMD_START, 14'd0, 16'd0, 16'h3FFF, 24'hFFFFFF}, 1'b1, WANT_ACCEPT},
		'{'{CMD_NEXT,  14'd0, 16'd0, 16'd0, 24'd0}, 1'b0, NO_WANT},
		// ignored command, every data bit set
		'{'{CMD_UNUSED, 14'h3FFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF}, 1'b0, NO_WANT}
	};

	// ------------------------------------------------------------------
	// Model step: apply one accepted command, return 1 if it owes a beat
	// ------------------------------------------------------------------
	function automatic bit walk_step(input walk_cmd_t c, output walk_beat_t r);
		logic [LINK_W-1:0] nxt;
		r = NO_WANT;
		case (c.cmd)
			CMD_WRITE: begin
				link_mem[c.index] = c.link;
				link_set[c.index] = 1'b1;
				return 1'b0;
			end
			CMD_START: begin
				if (c.start >= m_blocks || c.size == '0) begin
					walking = 1'b0;
					r.status = STAT_REJECT;
					return 1'b1;
				end
				walk_blk  = c.start;
				walk_left = c.size;
				walk_hops = '0;
				walking   = (c.start != '0);
				r.status  = STAT_ACCEPT;
				return 1'b1;
			end
			CMD_NEXT: begin
				if (!walking) begin
					r.status = STAT_IDLE;
					return 1'b1;
				end
				r.addr  = m_base + 40'(walk_blk) * 40'(BLOCK_BYTES);
				r.count = (walk_left < 24'(BLOCK_BYTES)) ? walk_left[COUNT_W-1:0]
					: 14'(BLOCK_BYTES);
				walk_left = walk_left - 24'(r.count);
				walk_hops = walk_hops + 17'd1;
				if (walk_left == '0 || walk_hops >= CHAIN_LIMIT) begin
					r.last = 1'b1;
				end else if (walk_blk >= m_entries || walk_blk >= TABLE_DEPTH) begin
					r.last = 1'b1;
				end else begin
					nxt = link_mem[walk_blk[INDEX_W-1:0]];
					if (nxt == '0 || (nxt & m_mask) != '0)
						r.last = 1'b1;
					else
						walk_blk = nxt;
				end
				if (r.last)
					walking = 1'b0;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// True when the next request would follow a link from a never-written entry.
	// Such reads are outside the block's contract, so the stimulus fills the entry first.
	function automatic bit unwritten_link_due(output logic [INDEX_W-1:0] idx);
		logic [SIZE_W-1:0] after;
		idx = walk_blk[INDEX_W-1:0];
		if (!walking)
			return 1'b0;
		after = (walk_left < 24'(BLOCK_BYTES)) ? '0 : walk_left - 24'(BLOCK_BYTES);
		return after != '0 && int'(walk_hops) + 1 < CHAIN_LIMIT
			&& walk_blk < m_entries && walk_blk < TABLE_DEPTH && !link_set[idx];
	endfunction

	// Mostly back to back, some short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	function automatic walk_cmd_t rand_cmd(input logic [CMD_W-1:0] code);
		walk_cmd_t c;
		c.cmd   = code;
		c.index = INDEX_W'($urandom);
		c.link  = LINK_W'($urandom);
		c.start = BLOCK_W'($urandom);
		c.size  = SIZE_W'($urandom);
		return c;
	endfunction

	// Links mostly stay in the working window so chains run deep
	function automatic logic [LINK_W-1:0] pick_link(input logic [15:0] lo, input logic [15:0] hi);
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return LINK_W'($urandom_range(lo, hi));
		else if (r < 80)
			return '0;
		else if (r < 90)
			return LINK_W'($urandom);
		else
			return LINK_W'($urandom_range(lo, hi)) | (m_mask & LINK_W'($urandom));
	endfunction

	// ------------------------------------------------------------------
	// Sender: one beat per call, model updated at the accepting edge
	// ------------------------------------------------------------------
	task automatic send_cmd(input walk_cmd_t c, input logic typed = 1'b0,
		input walk_beat_t want = NO_WANT);
		walk_beat_t got;
		bit owes;
		int gap;
		gap = pick_gap();
		if (tx_calm > 0) begin
			tx_calm--;
			gap = 0;
		end else if ($urandom_range(0, 99) < 3) begin
			tx_calm = $urandom_range(20, 80);
		end
		if (tx_steady)
			gap = 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, c.size, c.start, c.link, c.index};
		s_axis_tuser  <= c.cmd;
		do @(posedge clk); while (!s_axis_tready);
		owes = walk_step(c, got);
		if (owes)
			due_beats = {due_beats, (typed ? want : got)};
		if (c.cmd != CMD_UNUSED)
			items_sent++;
	endtask

	// Next-block request, preceded by a table write if the link it follows was never loaded
	task automatic request_next(input logic [15:0] lo, input logic [15:0] hi);
		walk_cmd_t c;
		logic [INDEX_W-1:0] idx;
		if (unwritten_link_due(idx)) begin
			c = rand_cmd(CMD_WRITE);
			c.index = idx;
			c.link  = pick_link(lo, hi);
			send_cmd(c);
		end
		send_cmd(rand_cmd(CMD_NEXT));
	endtask

	// Drop valid and wait until every owed beat is in, plus the pipeline depth
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (due_beats.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(input logic [ADDR_W-1:0] base, input logic [15:0] blocks,
		input logic [ENTRIES_W-1:0] entries, input logic [15:0] mask);
		cfg_we    <= 1'b1;
		cfg_index <= REG_BASE;
		cfg_data  <= base;
		@(posedge clk);
		cfg_index <= REG_BLOCKS;
		cfg_data  <= 40'(blocks);
		@(posedge clk);
		cfg_index <= REG_ENTRIES;
		cfg_data  <= 40'(entries);
		@(posedge clk);
		cfg_index <= REG_MASK;
		cfg_data  <= 40'(mask);
		@(posedge clk);
		cfg_we    <= 1'b0;
		m_base    = base;
		m_blocks  = blocks;
		m_entries = entries;
		m_mask    = mask;
	endtask

	// One random phase: reprogram while idle, then mostly well-formed walks
	// inside the window [lo, hi], some loose writes and noise.
	task automatic run_phase(input logic [ADDR_W-1:0] base, input logic [15:0] blocks,
		input logic [ENTRIES_W-1:0] entries, input logic [15:0] mask,
		input logic [15:0] lo, input logic [15:0] hi, input int quota, input bit squeeze);
		walk_cmd_t c;
		int stop_at, pause_at, pick, hops;
		bit paused, squeezed;
		wait_drained();
		program_regs(base, blocks, entries, mask);
		stop_at  = items_sent + quota;
		pause_at = items_sent + quota / 2;
		paused   = 1'b0;
		squeezed = !squeeze;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (!paused && items_sent >= pause_at) begin
				// sender holds until the block has answered everything
				wait_drained();
				paused = 1'b1;
			end else if (!squeezed && items_sent >= pause_at + 20) begin
				// receiver stalls for a long stretch while a walk keeps coming,
				// so the output register and the held item back up to the input
				squeezed    = 1'b1;
				rx_hold_req = 300;
				tx_steady   = 1'b1;
				c = rand_cmd(CMD_START);
				c.start = lo;
				c.size  = 24'hFFFFFF;
				send_cmd(c);
				repeat (16) request_next(lo, hi);
				tx_steady = 1'b0;
			end else if (pick < 15) begin
				c = rand_cmd(CMD_WRITE);
				c.index = INDEX_W'($urandom_range(lo, hi));
				c.link  = pick_link(lo, hi);
				send_cmd(c);
			end else if (pick < 25) begin
				// noise: loose starts, ignored commands, stray requests and writes
				case ($urandom_range(0, 3))
					0: send_cmd(rand_cmd(CMD_START));
					1: send_cmd(rand_cmd(CMD_UNUSED));
					2: request_next(lo, hi);
					default: send_cmd(rand_cmd(CMD_WRITE));
				endcase
			end else begin
				c = rand_cmd(CMD_START);
				if ($urandom_range(0, 99) < 85)
					c.start = BLOCK_W'($urandom_range(lo, hi));
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: c.size = SIZE_W'($urandom_range(1, 40000));
					6, 7, 8: c.size = SIZE_W'($urandom_range(1, 400000));
					default: ;  // full 24-bit range, zero included
				endcase
				send_cmd(c);
				hops = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 6);
				repeat (hops) request_next(lo, hi);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Receiver: random ready, long holds on request, checks each beat
	// ------------------------------------------------------------------
	task automatic check_beat();
		walk_beat_t want, got;
		got.status = status_t'(m_axis_tuser);
		got.addr   = m_axis_tdata[ADDR_W-1:0];
		got.count  = m_axis_tdata[ADDR_W+COUNT_W-1:ADDR_W];
		got.last   = m_axis_tlast;
		if (due_beats.size() == 0) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("%0t: beat with nothing owed: status %0d addr %h count %0d last %0d",
					$time, got.status, got.addr, got.count, got.last);
			return;
		end
		want = due_beats.pop_front();
		case (want.status)
			STAT_BLOCK: begin
				block_beats++;
				if (want.last)
					last_beats++;
			end
			STAT_REJECT: reject_beats++;
			STAT_IDLE: idle_beats++;
			default: ;
		endcase
		if (got !== want) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display({"%0t: mismatch: expected status %0d addr %h count %0d last %0d,",
					" got status %0d addr %h count %0d last %0d"}, $time,
					want.status, want.addr, want.count, want.last,
					got.status, got.addr, got.count, got.last);
		end
	endtask

	initial begin : drain_side
		int gap_left, calm_left;
		gap_left  = 0;
		calm_left = 0;
		forever begin
			if (rx_hold_req > 0) begin
				gap_left    = rx_hold_req;
				rx_hold_req = 0;
				calm_left   = 0;
			end
			if (gap_left > 0) begin
				m_axis_tready <= 1'b0;
				gap_left--;
			end else if (calm_left > 0) begin
				m_axis_tready <= 1'b1;
				calm_left--;
			end else begin
				if ($urandom_range(0, 99) < 2)
					calm_left = $urandom_range(30, 120);
				gap_left = pick_gap();
				m_axis_tready <= (gap_left == 0);
				if (gap_left > 0)
					gap_left--;
			end
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				check_beat();
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : stimulus
		int row, top, lo4, hi4;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (row = 0; row < DIRECTED_ROWS; row++) begin
			if (row == FIRST_CFG_ROW) begin
				wait_drained();
				program_regs(40'hFF_FFFF_0000, 16'hFFFF, 15'd16384, 16'h8000);
			end
			send_cmd(plan[row].cmd, plan[row].typed, plan[row].want);
		end

		// top of the table, full partition, random base, two special bits
		run_phase({8'($urandom), 32'($urandom)}, 16'hFFFF, 15'd16384, 16'hC000,
			16'd16320, 16'd16383, 600, 1'b1);
		// base zero, small partition, table shorter than the partition, no mask
		run_phase(40'd0, 16'd96, 15'd40, 16'h0000, 16'd1, 16'd95, 600, 1'b0);
		// one-block partition, empty table, every link special, top base
		run_phase(40'hFF_FFFF_FFFF, 16'd1, 15'd0, 16'hFFFF, 16'd0, 16'd0, 100, 1'b0);
		// everything random
		top = $urandom_range(1, 65534);
		lo4 = $urandom_range(1, top);
		hi4 = (top - lo4 > 80) ? lo4 + 80 : top;
		run_phase({8'($urandom), 32'($urandom)}, 16'(top + 1),
			15'($urandom_range(0, 16384)),
			16'($urandom) & 16'($urandom) & 16'($urandom),
			16'(lo4), 16'(hi4), 600, 1'b0);

		wait_drained();
		$display("Run covered %0d commands over five register settings: %0d block beats,",
			items_sent, block_beats);
		$display("%0d of them ending a walk, %0d rejected starts, %0d answers with no walk.",
			last_beats, reject_beats, idle_beats);
		if (fail_count == 0 && due_beats.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Watchdog, far above the slowest legal run
	initial begin : watchdog
		#5_000_000;
		$display("Timed out with %0d beats still owed", due_beats.size());
		$display("FAILURE");
		$finish;
	end

endmodule
